FILE: hdl/h2r_pkg.sv
// Package with the shared types and constants of the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

    localparam int CHAN_W = 8;
    localparam int SPAN_W = 16;

    // Reciprocal of 255 for any 16-bit dividend: q = (y * 0x8081) >> 23.
    localparam logic [SPAN_W-1:0] DIV255_MAGIC = 16'h8081;
    localparam int DIV255_SHIFT = 23;

    typedef struct packed {
        logic [SPAN_W-1:0] v1;
        logic [SPAN_W-1:0] diff;
    } h2r_span_t;

endpackage

`default_nettype wire

FILE: hdl/h2r_prep.sv
// First pipeline stage: the v1 / v2 span and the three shifted hue positions.
`default_nettype none

module h2r_prep #(
    parameter int HUE_BITS = 12
) (
    input  wire logic                       clk,
    input  wire logic [HUE_BITS-1:0]        hue,
    input  wire logic [h2r_pkg::CHAN_W-1:0] saturation,
    input  wire logic [h2r_pkg::CHAN_W-1:0] lightness,
    output h2r_pkg::h2r_span_t              span,
    output logic [HUE_BITS+1:0]             t_red,
    output logic [HUE_BITS+1:0]             t_green,
    output logic [HUE_BITS+1:0]             t_blue
);

    localparam int TW = HUE_BITS + 3;
    localparam logic [TW-1:0] ONE  = TW'(1) << HUE_BITS;
    localparam logic [TW-1:0] TURN = ONE + ONE + ONE;

    h2r_pkg::h2r_span_t  span_reg;
    h2r_pkg::h2r_span_t  span_next;
    logic [HUE_BITS+1:0] t_red_reg;
    logic [HUE_BITS+1:0] t_red_next;
    logic [HUE_BITS+1:0] t_green_reg;
    logic [HUE_BITS+1:0] t_green_next;
    logic [HUE_BITS+1:0] t_blue_reg;
    logic [HUE_BITS+1:0] t_blue_next;

    logic [15:0] ls;
    logic [16:0] l255;
    logic [16:0] s255;
    logic [16:0] l510;
    logic [16:0] v2_wide;
    logic [16:0] v1_wide;
    logic [TW-1:0] t3;
    logic [TW-1:0] t_plus1;
    logic [TW-1:0] t_plus2;

    always_comb
    begin
        ls   = 16'(lightness) * 16'(saturation);
        l255 = {1'b0, lightness, 8'd0} - 17'(lightness);
        s255 = {1'b0, saturation, 8'd0} - 17'(saturation);
        l510 = {lightness, 9'd0} - {8'd0, lightness, 1'b0};
        if (!lightness[7])
        begin
            v2_wide = l255 + 17'(ls);
        end
        else
        begin
            v2_wide = l255 + s255 - 17'(ls);
        end
        v1_wide = l510 - v2_wide;
        span_next.v1   = v1_wide[15:0];
        span_next.diff = 16'(v2_wide - v1_wide);

        t3      = TW'(hue) + TW'(hue) + TW'(hue);
        t_plus1 = t3 + ONE;
        t_plus2 = t3 + ONE + ONE;
        if (t_plus1 >= TURN)
        begin
            t_plus1 = t_plus1 - TURN;
        end
        if (t_plus2 >= TURN)
        begin
            t_plus2 = t_plus2 - TURN;
        end
        t_green_next = t3[HUE_BITS+1:0];
        t_red_next   = t_plus1[HUE_BITS+1:0];
        t_blue_next  = t_plus2[HUE_BITS+1:0];
    end

    always_ff @(posedge clk)
    begin
        span_reg    <= span_next;
        t_red_reg   <= t_red_next;
        t_green_reg <= t_green_next;
        t_blue_reg  <= t_blue_next;
    end

    assign span    = span_reg;
    assign t_red   = t_red_reg;
    assign t_green = t_green_reg;
    assign t_blue  = t_blue_reg;

endmodule

`default_nettype wire

FILE: hdl/h2r_ramp.sv
// Hue ramp of one channel: ramp weight, scaled blend of v1 and v2, and division by 255.
`default_nettype none

module h2r_ramp #(
    parameter int HUE_BITS = 12
) (
    input  wire logic                        clk,
    input  wire logic [HUE_BITS+1:0]         t,
    input  wire h2r_pkg::h2r_span_t          span,
    output logic [h2r_pkg::CHAN_W-1:0]       chan
);

    localparam int TW = HUE_BITS + 3;
    localparam int PW = HUE_BITS + 17;
    localparam logic [TW-1:0] ONE   = TW'(1) << HUE_BITS;
    localparam logic [TW-1:0] THREE = ONE + ONE + ONE;
    localparam logic [TW-1:0] FOUR  = ONE + ONE + ONE + ONE;

    logic [HUE_BITS:0] x_reg;
    logic [HUE_BITS:0] x_next;
    logic [h2r_pkg::SPAN_W-1:0] y_reg;
    logic [h2r_pkg::SPAN_W-1:0] y_next;
    logic [h2r_pkg::CHAN_W-1:0] chan_reg;
    logic [h2r_pkg::CHAN_W-1:0] chan_next;

    logic [TW-1:0] t2;
    logic [TW-1:0] fall;
    logic [PW-1:0] prod;
    logic [16:0]   sum;
    logic [31:0]   quot;

    always_comb
    begin
        t2   = {t, 1'b0};
        fall = FOUR - t2;
        if (t2 < ONE)
        begin
            x_next = t2[HUE_BITS:0];
        end
        else if (t2 < THREE)
        begin
            x_next = ONE[HUE_BITS:0];
        end
        else if (t2 < FOUR)
        begin
            x_next = fall[HUE_BITS:0];
        end
        else
        begin
            x_next = '0;
        end

        prod   = PW'(span.diff) * PW'(x_reg);
        sum    = 17'(span.v1) + prod[PW-1:HUE_BITS];
        y_next = sum[15:0];

        quot      = 32'(y_reg) * 32'(h2r_pkg::DIV255_MAGIC);
        chan_next = quot[h2r_pkg::DIV255_SHIFT+h2r_pkg::CHAN_W-1:h2r_pkg::DIV255_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

FILE: hdl/hsl_to_rgb_converter_core.sv
// Top level of the pipelined HSL to RGB converter.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------
//  request  | start, busy        | hue, saturation, lightness
//  result   | done (strobe)      | red, green, blue, packed_color
//
// One request is taken in every cycle; busy is always low.
// Each result is registered in order after its request: one stage for the span
// and hue offsets, then the ramp weight, the multiply, and the divide by 255.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module hsl_to_rgb_converter_core #(
    parameter int HUE_BITS = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [HUE_BITS-1:0] hue,
    input  wire logic [7:0]          saturation,
    input  wire logic [7:0]          lightness,
    output logic                     done,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [23:0]              packed_color
);

    localparam int DEPTH = 4;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    h2r_pkg::h2r_span_t  span_s1;
    h2r_pkg::h2r_span_t  span_s2_reg;
    logic [HUE_BITS+1:0] t_red;
    logic [HUE_BITS+1:0] t_green;
    logic [HUE_BITS+1:0] t_blue;

    assign busy = 1'b0;

    always_comb
    begin
        valid_next = {valid_reg[DEPTH-2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    h2r_prep #(
        .HUE_BITS(HUE_BITS)
    ) u_prep (
        .clk(clk),
        .hue(hue),
        .saturation(saturation),
        .lightness(lightness),
        .span(span_s1),
        .t_red(t_red),
        .t_green(t_green),
        .t_blue(t_blue)
    );

    always_ff @(posedge clk)
    begin
        span_s2_reg <= span_s1;
    end

    h2r_ramp #(
        .HUE_BITS(HUE_BITS)
    ) u_ramp_red (
        .clk(clk),
        .t(t_red),
        .span(span_s2_reg),
        .chan(red)
    );

    h2r_ramp #(
        .HUE_BITS(HUE_BITS)
    ) u_ramp_green (
        .clk(clk),
        .t(t_green),
        .span(span_s2_reg),
        .chan(green)
    );

    h2r_ramp #(
        .HUE_BITS(HUE_BITS)
    ) u_ramp_blue (
        .clk(clk),
        .t(t_blue),
        .span(span_s2_reg),
        .chan(blue)
    );

    assign done         = valid_reg[DEPTH-1];
    assign packed_color = {red, green, blue};

    a_done_follows_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start, DEPTH)
    ) else $error("Result strobe without a matching request.");

    a_gray_is_lightness: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && saturation == 8'd0) |-> ##4
            (done && red == $past(lightness, DEPTH) && green == $past(lightness, DEPTH)
             && blue == $past(lightness, DEPTH))
    ) else $error("Zero saturation did not give lightness on every channel.");

    a_start_reaches_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        start |-> ##4 done
    ) else $error("Accepted request produced no result.");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the pipelined HSL to RGB converter core.
`timescale 1ns / 1ps

module testbench;

    localparam int HUE_BITS = 12;
    localparam int DIRECTED_COUNT = 21;
    localparam int PHASE_ITEMS = 576;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [h2r_pkg::CHAN_W-1:0] red;
        logic [h2r_pkg::CHAN_W-1:0] green;
        logic [h2r_pkg::CHAN_W-1:0] blue;
        logic [23:0]                packed_color;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [7:0]          saturation;
        logic [7:0]          lightness;
        logic                preset;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
    } directed_row_t;

    // Rows with preset set carry a result that is obvious from the inputs.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{12'd0,    8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{12'd4095, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{12'd2048, 8'd0,   8'd128, 1'b1, 8'd128, 8'd128, 8'd128},
        '{12'd0,    8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{12'd4095, 8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{12'd0,    8'd255, 8'd127, 1'b1, 8'd254, 8'd0,   8'd0},
        '{12'd0,    8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd682,  8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd683,  8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd1365, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd1366, 8'd200, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd2048, 8'd1,   8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd2730, 8'd254, 8'd64,  1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd2731, 8'd128, 8'd192, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd3413, 8'd255, 8'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd3414, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd4095, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd1024, 8'd37,  8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd3072, 8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd341,  8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{12'd0,    8'd1,   8'd254, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [HUE_BITS-1:0] hue;
    logic [7:0]          saturation;
    logic [7:0]          lightness;
    logic                done;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [23:0]         packed_color;

    logic   preset_valid;
    pixel_t preset_pixel;
    int     gap_pct;
    int     taken_count = 0;
    int     fault_count = 0;
    int     quiet_cycles = 0;
    pixel_t pending_pixels [$];

    hsl_to_rgb_converter_core #(
        .HUE_BITS(HUE_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .hue(hue),
        .saturation(saturation),
        .lightness(lightness),
        .done(done),
        .red(red),
        .green(green),
        .blue(blue),
        .packed_color(packed_color)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] ramp_level(input logic [63:0] v1, v2, t);
        logic [63:0] one;
        logic [63:0] num;
        one = 64'd1 << HUE_BITS;
        if (2 * t < one)
            num = v1 * one + (v2 - v1) * (2 * t);
        else if (2 * t < 3 * one)
            num = v2 * one;
        else if (t < 2 * one)
            num = v1 * one + (v2 - v1) * (4 * one - 2 * t);
        else
            num = v1 * one;
        num = num / (255 * one);
        return (num > 255) ? 8'd255 : num[7:0];
    endfunction

    function automatic pixel_t hsl_to_rgb(input logic [HUE_BITS-1:0] h,
                                          input logic [7:0] s, input logic [7:0] l);
        logic [63:0] one;
        logic [63:0] sat;
        logic [63:0] lit;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] t;
        pixel_t      px;
        one = 64'd1 << HUE_BITS;
        sat = s;
        lit = l;
        if (s == 8'd0)
        begin
            px.red = l;
            px.green = l;
            px.blue = l;
        end
        else
        begin
            if (2 * lit < 255)
                v2 = lit * (255 + sat);
            else
                v2 = 255 * lit + 255 * sat - lit * sat;
            v1 = 2 * 255 * lit - v2;
            t = h;
            t = 3 * t;
            px.red = ramp_level(v1, v2, (t + one) % (3 * one));
            px.green = ramp_level(v1, v2, t % (3 * one));
            px.blue = ramp_level(v1, v2, (t + 2 * one) % (3 * one));
        end
        px.packed_color = {px.red, px.green, px.blue};
        return px;
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;
        if (start && !busy)
        begin
            if (preset_valid)
                pending_pixels.push_back(preset_pixel);
            else
                pending_pixels.push_back(hsl_to_rgb(hue, saturation, lightness));
            taken_count <= taken_count + 1;
        end
        if (done)
        begin
            if (pending_pixels.size() == 0)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("Unexpected result at %0t: %h", $realtime, packed_color);
                fault_count <= fault_count + 1;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (red !== want.red || green !== want.green || blue !== want.blue
                    || packed_color !== want.packed_color)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display({"Mismatch at %0t: expected r=%h g=%h b=%h p=%h, ",
                                  "got r=%h g=%h b=%h p=%h"},
                                 $realtime, want.red, want.green, want.blue,
                                 want.packed_color, red, green, blue, packed_color);
                    fault_count <= fault_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired at %0t", $realtime);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic issue_pixel(input logic [HUE_BITS-1:0] h, input logic [7:0] s,
                               input logic [7:0] l, input logic preset, input pixel_t px);
        int target;
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        hue = h;
        saturation = s;
        lightness = l;
        preset_valid = preset;
        preset_pixel = px;
        target = taken_count + 1;
        do
            @(negedge clk);
        while (taken_count != target);
    endtask

    task automatic drain_pipeline();
        start = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(input int pct);
        logic [HUE_BITS-1:0] h;
        logic [7:0]          s;
        logic [7:0]          l;
        int                  pick;
        gap_pct = pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                h = HUE_BITS'(($urandom_range(5) * 4096) / 6 + $urandom_range(2) - 1);
            else
                h = HUE_BITS'($urandom_range(4095));
            pick = $urandom_range(99);
            if (pick < 10)
                s = 8'd0;
            else if (pick < 20)
                s = 8'd255;
            else
                s = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 10)
                l = 8'($urandom_range(128, 127));
            else if (pick < 15)
                l = 8'd0;
            else if (pick < 20)
                l = 8'd255;
            else
                l = 8'($urandom_range(255));
            issue_pixel(h, s, l, 1'b0, '0);
        end
        drain_pipeline();
    endtask

    initial
    begin
        directed_row_t row;
        rst_n = 1'b0;
        start = 1'b0;
        hue = '0;
        saturation = '0;
        lightness = '0;
        preset_valid = 1'b0;
        preset_pixel = '0;
        gap_pct = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        gap_pct = 22;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            issue_pixel(row.hue, row.saturation, row.lightness, row.preset,
                        '{row.red, row.green, row.blue, {row.red, row.green, row.blue}});
        end
        drain_pipeline();

        random_phase(22);
        random_phase(66);
        random_phase(0);

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fault_count == 0 && pending_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
